// File: design/toalu_pkg.sv
// Package for the two-operand ALU: operation codes, operand widths
// and the status flag type. No dependencies.
`timescale 1ns / 1ps

package toalu_pkg;

   localparam int unsigned DATA_W = 16;
   localparam int unsigned OP_W   = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_MOV  = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
   localparam logic [OP_W-1:0] OP_ADDC = 4'd2;
   localparam logic [OP_W-1:0] OP_SUBC = 4'd3;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd4;
   localparam logic [OP_W-1:0] OP_CMP  = 4'd5;
   localparam logic [OP_W-1:0] OP_BIT  = 4'd6;
   localparam logic [OP_W-1:0] OP_BIC  = 4'd7;
   localparam logic [OP_W-1:0] OP_BIS  = 4'd8;
   localparam logic [OP_W-1:0] OP_XOR  = 4'd9;
   localparam logic [OP_W-1:0] OP_AND  = 4'd10;

   // Operand masks and sign bits
   localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00FF;
   localparam logic [DATA_W-1:0] WORD_MASK = 16'hFFFF;
   localparam logic [DATA_W-1:0] BYTE_SIGN = 16'h0080;
   localparam logic [DATA_W-1:0] WORD_SIGN = 16'h8000;

   // Status flags
   typedef struct packed {
      logic v;
      logic n;
      logic z;
      logic c;
   } flags_type;

endpackage

// File: design/toalu_exec.sv
// Execute logic of the two-operand ALU: one pass from operands and kept
// flags to result, write-back and new flags. Depends on toalu_pkg.
`timescale 1ns / 1ps

module toalu_exec import toalu_pkg::*; (
   input  logic [OP_W-1:0]   operation,
   input  logic              byte_mode,
   input  logic [DATA_W-1:0] src_value,
   input  logic [DATA_W-1:0] dst_value,
   input  flags_type         flags_cur,
   output logic [DATA_W-1:0] result_value,
   output logic              write_back,
   output flags_type         flags_nxt
);

   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] sign;
   logic [DATA_W-1:0] src_m;
   logic [DATA_W-1:0] dst_m;
   logic [DATA_W-1:0] addend;
   logic              cin;
   logic [DATA_W:0]   sum;
   logic [DATA_W-1:0] sum_lo;
   logic              sum_carry;
   logic [DATA_W-1:0] logic_res;
   logic              res_zero;
   logic              res_neg;

   // Operand masking by size
   assign mask  = byte_mode ? BYTE_MASK : WORD_MASK;
   assign sign  = byte_mode ? BYTE_SIGN : WORD_SIGN;
   assign src_m = src_value & mask;
   assign dst_m = dst_value & mask;

   // Adder: subtract forms add the inverted source
   always_comb begin
      addend = src_m;
      cin    = 1'b0;
      if (operation inside {OP_SUBC, OP_SUB, OP_CMP}) begin
         addend = ~src_value & mask;
      end
      if (operation inside {OP_ADDC, OP_SUBC}) begin
         cin = flags_cur.c;
      end else if (operation inside {OP_SUB, OP_CMP}) begin
         cin = 1'b1;
      end
   end

   assign sum       = {1'b0, dst_m} + {1'b0, addend} + {{DATA_W{1'b0}}, cin};
   assign sum_lo    = sum[DATA_W-1:0] & mask;
   assign sum_carry = byte_mode ? sum[8] : sum[DATA_W];

   // Result select and flag update
   always_comb begin
      result_value = '0;
      write_back   = 1'b1;
      flags_nxt    = flags_cur;
      logic_res    = '0;
      case (operation)
         OP_ADD, OP_ADDC, OP_SUBC, OP_SUB, OP_CMP: begin
            logic_res = sum_lo;
         end
         OP_MOV:         logic_res = src_m;
         OP_BIT, OP_AND: logic_res = src_m & dst_m;
         OP_BIC:         logic_res = ~src_value & dst_m;
         OP_BIS:         logic_res = src_m | dst_m;
         OP_XOR:         logic_res = src_m ^ dst_m;
         default:        logic_res = '0;
      endcase
      res_zero = ((logic_res & mask) == '0);
      res_neg  = |(logic_res & sign);
      result_value = logic_res & mask;

      case (operation)
         OP_ADD, OP_ADDC, OP_SUBC, OP_SUB, OP_CMP: begin
            flags_nxt.c = sum_carry;
            flags_nxt.z = res_zero;
            flags_nxt.n = res_neg;
            flags_nxt.v = |((addend ^ sum_lo) & (dst_m ^ sum_lo) & sign);
            if (operation == OP_CMP) begin
               write_back = 1'b0;
            end
         end
         OP_BIT, OP_AND: begin
            flags_nxt.c = ~res_zero;
            flags_nxt.z = res_zero;
            flags_nxt.n = res_neg;
            flags_nxt.v = 1'b0;
            if (operation == OP_BIT) begin
               write_back = 1'b0;
            end
         end
         OP_XOR: begin
            // overflow when both operands are negative
            flags_nxt.c = ~res_zero;
            flags_nxt.z = res_zero;
            flags_nxt.n = res_neg;
            flags_nxt.v = |(src_m & dst_m & sign);
         end
         OP_MOV, OP_BIC, OP_BIS: begin
            flags_nxt = flags_cur;
         end
         default: begin
            // unused codes act as no operation
            write_back = 1'b0;
         end
      endcase
   end

endmodule

// File: design/two_operand_alu_with_flags.sv
// Top level of the two-operand ALU with status flags: input register,
// execute logic, result register and kept flags. Depends on toalu_pkg, toalu_exec.
`timescale 1ns / 1ps
//
//  channel  direction  ports                                       accept
//  req      in         req_valid, req_stall, operation..dst_value  valid & !stall
//  rsp      out        rsp_valid, rsp_stall, result..flags         valid & !stall
//
//  One word per cycle sustained while rsp_stall is low. An accepted word moves
//  from the input register into the result register and leaves from there.
//  The kept carry feeds back through a single flop, updated as a word moves
//  into the result register, so back-to-back addc/subc see the right carry.
//  Synchronous active-high reset clears the valid bits and all four flags.
//  A stalled result holds; the input register holds behind it and then
//  stalls the request side.

module two_operand_alu_with_flags import toalu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_operation,
   input  logic              req_byte_mode,
   input  logic [DATA_W-1:0] req_src_value,
   input  logic [DATA_W-1:0] req_dst_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_result_value,
   output logic              rsp_write_back,
   output logic              rsp_carry_flag,
   output logic              rsp_zero_flag,
   output logic              rsp_negative_flag,
   output logic              rsp_overflow_flag
);

   logic              in_valid_ff;
   logic [OP_W-1:0]   in_op_ff;
   logic              in_byte_ff;
   logic [DATA_W-1:0] in_src_ff;
   logic [DATA_W-1:0] in_dst_ff;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_result_ff;
   logic              out_wb_ff;
   flags_type         flags_ff;
   flags_type         flags_in;
   logic [DATA_W-1:0] exec_result;
   logic              exec_wb;
   logic              advance;
   logic              in_load;

   // Pipeline control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_byte_mode;
         in_src_ff  <= req_src_value;
         in_dst_ff  <= req_dst_value;
      end
   end

   // Execute
   toalu_exec u_exec (
      .operation    (in_op_ff),
      .byte_mode    (in_byte_ff),
      .src_value    (in_src_ff),
      .dst_value    (in_dst_ff),
      .flags_cur    (flags_ff),
      .result_value (exec_result),
      .write_back   (exec_wb),
      .flags_nxt    (flags_in)
   );

   // Kept status flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= exec_result;
         out_wb_ff     <= exec_wb;
      end
   end

   // Flag outputs come from the kept flags, which change only on advance or reset
   assign rsp_valid         = out_valid_ff;
   assign rsp_result_value  = out_result_ff;
   assign rsp_write_back    = out_wb_ff;
   assign rsp_carry_flag    = flags_ff.c;
   assign rsp_zero_flag     = flags_ff.z;
   assign rsp_negative_flag = flags_ff.n;
   assign rsp_overflow_flag = flags_ff.v;

endmodule
